>>> sv/i2cms_pkg.sv
`timescale 1ns / 1ps
package i2cms_pkg;
   localparam int MaxBytesDefault    = 256;
   localparam int MaxMessagesDefault = 255;

   localparam logic [1:0] CMD_HEADER = 2'd0;
   localparam logic [1:0] CMD_WRITE  = 2'd1;
   localparam logic [1:0] CMD_REPLY  = 2'd2;

   localparam logic [3:0] ACT_START   = 4'd0;
   localparam logic [3:0] ACT_RESTART = 4'd1;
   localparam logic [3:0] ACT_SEND    = 4'd2;
   localparam logic [3:0] ACT_ACK     = 4'd3;
   localparam logic [3:0] ACT_NACK    = 4'd4;
   localparam logic [3:0] ACT_NOACK   = 4'd5;
   localparam logic [3:0] ACT_READ    = 4'd6;
   localparam logic [3:0] ACT_STOP    = 4'd7;
   localparam logic [3:0] ACT_DONE    = 4'd8;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_ADDR_NACK = 2'd1;
   localparam logic [1:0] ST_IO_ERROR  = 2'd2;
   localparam logic [1:0] ST_WR_NACK   = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE, PH_ADDR, PH_WDATA, PH_WREPLY, PH_RREPLY
   } phase_type;

   typedef struct packed {
      logic [3:0] action;
      logic [7:0] data;
      logic [1:0] status;
      logic [7:0] count;
   } result_type;

   // up to three results per accepted word
   typedef struct packed {
      logic [1:0] num;
      result_type r0;
      result_type r1;
      result_type r2;
   } bundle_type;
endpackage

>>> sv/i2cms_front.sv
`timescale 1ns / 1ps
module i2cms_front #(
   parameter int MAX_BYTES    = i2cms_pkg::MaxBytesDefault,
   parameter int MAX_MESSAGES = i2cms_pkg::MaxMessagesDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic                   in_ready,
   input  logic [1:0]             command,
   input  logic [6:0]             slave_address,
   input  logic                   is_read,
   input  logic                   skip_start,
   input  logic                   keep_on_nack,
   input  logic                   skip_read_ack,
   input  logic                   skip_stop,
   input  logic [8:0]             byte_count,
   input  logic                   final_message,
   input  logic [7:0]             data_byte,
   input  logic                   target_nack,
   input  logic                   arbitration_lost,
   output logic                   out_valid,
   output i2cms_pkg::bundle_type  out_bundle
);
   localparam int CW = (MAX_BYTES < 2) ? 1 : $clog2(MAX_BYTES + 1);
   localparam int CapI = (MAX_MESSAGES < 255) ? MAX_MESSAGES : 255;
   localparam logic [7:0] Cap = 8'(CapI);

   i2cms_pkg::phase_type phase_ff, phase_in;
   logic in_transfer_ff, in_transfer_in;
   logic [CW-1:0] left_ff, left_in;
   logic f_read_ff, f_ign_ff, f_sra_ff, f_ss_ff, f_fin_ff;
   logic f_read_in, f_ign_in, f_sra_in, f_ss_in, f_fin_in;
   logic [7:0] cnt_ff, cnt_in;

   always_comb begin
      i2cms_pkg::result_type res [3];
      logic [1:0] n;
      logic [CW-1:0] bl;
      logic [7:0] cc;
      logic fin_msg, end_xfer, start_dat, rack;
      logic [1:0] st;
      phase_in = phase_ff; in_transfer_in = in_transfer_ff; left_in = left_ff;
      f_read_in = f_read_ff; f_ign_in = f_ign_ff; f_sra_in = f_sra_ff;
      f_ss_in = f_ss_ff; f_fin_in = f_fin_ff; cnt_in = cnt_ff;
      for (int i = 0; i < 3; i++) res[i] = '0;
      n = '0; bl = left_ff; cc = cnt_ff;
      fin_msg = 1'b0; end_xfer = 1'b0; start_dat = 1'b0; rack = 1'b0;
      st = i2cms_pkg::ST_OK;
      case (command)
         i2cms_pkg::CMD_HEADER: begin
            if (phase_ff == i2cms_pkg::PH_IDLE) begin
               f_read_in = is_read; f_ign_in = keep_on_nack;
               f_sra_in = skip_read_ack; f_ss_in = skip_stop; f_fin_in = final_message;
               bl = (32'(byte_count) > MAX_BYTES) ? CW'(MAX_BYTES) : CW'(byte_count);
               in_transfer_in = 1'b1;
               if (!skip_start) begin
                  res[0].action = in_transfer_ff ? i2cms_pkg::ACT_RESTART
                                                 : i2cms_pkg::ACT_START;
                  res[1].action = i2cms_pkg::ACT_SEND;
                  res[1].data = {slave_address, is_read};
                  n = 2'd2;
                  phase_in = i2cms_pkg::PH_ADDR;
               end else begin
                  start_dat = 1'b1;
               end
            end
         end
         i2cms_pkg::CMD_WRITE: begin
            if (phase_ff == i2cms_pkg::PH_WDATA) begin
               res[0].action = i2cms_pkg::ACT_SEND;
               res[0].data = data_byte;
               n = 2'd1;
               phase_in = i2cms_pkg::PH_WREPLY;
            end
         end
         i2cms_pkg::CMD_REPLY: begin
            case (phase_ff)
               i2cms_pkg::PH_ADDR: begin
                  if (arbitration_lost) begin
                     end_xfer = 1'b1; st = i2cms_pkg::ST_IO_ERROR;
                  end else if (target_nack && !f_ign_ff) begin
                     end_xfer = 1'b1; st = i2cms_pkg::ST_ADDR_NACK;
                  end else start_dat = 1'b1;
               end
               i2cms_pkg::PH_WREPLY: begin
                  if (arbitration_lost) begin
                     end_xfer = 1'b1; st = i2cms_pkg::ST_IO_ERROR;
                  end else if (target_nack && !f_ign_ff) begin
                     end_xfer = 1'b1; st = i2cms_pkg::ST_WR_NACK;
                  end else begin
                     if (bl != '0) bl = bl - 1'b1;
                     if (bl == '0) fin_msg = 1'b1;
                     else phase_in = i2cms_pkg::PH_WDATA;
                  end
               end
               i2cms_pkg::PH_RREPLY: begin
                  res[0].action = i2cms_pkg::ACT_READ;
                  res[0].data = data_byte;
                  n = 2'd1;
                  if (bl != '0) bl = bl - 1'b1;
                  if (bl == '0) fin_msg = 1'b1;
                  else rack = 1'b1;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      if (start_dat) begin
         if (bl == '0) fin_msg = 1'b1;
         else if (f_read_in) rack = 1'b1;
         else phase_in = i2cms_pkg::PH_WDATA;
      end
      if (rack) begin
         res[n].action = f_sra_in ? i2cms_pkg::ACT_NOACK
                       : (bl > CW'(1)) ? i2cms_pkg::ACT_ACK : i2cms_pkg::ACT_NACK;
         n = n + 1'b1;
         phase_in = i2cms_pkg::PH_RREPLY;
      end
      if (fin_msg) begin
         if (cc < Cap) cc = cc + 1'b1;
         if (f_fin_in) end_xfer = 1'b1;
         else phase_in = i2cms_pkg::PH_IDLE;
      end
      left_in = bl;
      cnt_in = cc;
      if (end_xfer) begin
         if (!f_ss_in) begin
            res[n].action = i2cms_pkg::ACT_STOP;
            n = n + 1'b1;
         end
         res[n].action = i2cms_pkg::ACT_DONE;
         res[n].status = st;
         res[n].count = cc;
         n = n + 1'b1;
         phase_in = i2cms_pkg::PH_IDLE; in_transfer_in = 1'b0; left_in = '0;
         f_read_in = 1'b0; f_ign_in = 1'b0; f_sra_in = 1'b0; f_ss_in = 1'b0;
         f_fin_in = 1'b0; cnt_in = '0;
      end
      out_bundle.num = n;
      out_bundle.r0 = res[0];
      out_bundle.r1 = res[1];
      out_bundle.r2 = res[2];
   end

   assign out_valid = in_valid && in_ready && (out_bundle.num != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= i2cms_pkg::PH_IDLE; in_transfer_ff <= 1'b0; left_ff <= '0;
         f_read_ff <= 1'b0; f_ign_ff <= 1'b0; f_sra_ff <= 1'b0;
         f_ss_ff <= 1'b0; f_fin_ff <= 1'b0; cnt_ff <= '0;
      end else if (in_valid && in_ready) begin
         phase_ff <= phase_in; in_transfer_ff <= in_transfer_in; left_ff <= left_in;
         f_read_ff <= f_read_in; f_ign_ff <= f_ign_in; f_sra_ff <= f_sra_in;
         f_ss_ff <= f_ss_in; f_fin_ff <= f_fin_in; cnt_ff <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      left_ff <= CW'(MAX_BYTES))
      else $error("byte count past limit");
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != i2cms_pkg::PH_IDLE) |-> in_transfer_ff)
      else $error("active message outside transfer");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff > Cap) |-> 1'b0)
      else $error("message count past cap");
endmodule

>>> sv/i2cms_back.sv
`timescale 1ns / 1ps
module i2cms_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  i2cms_pkg::bundle_type in_bundle,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_stall,
   output logic [3:0]            action,
   output logic [7:0]            data,
   output logic [1:0]            status,
   output logic [7:0]            count,
   output logic                  last
);
   // two-entry queue of result bundles
   i2cms_pkg::bundle_type q_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] fill_ff;
   logic [1:0] idx_ff;
   i2cms_pkg::bundle_type head;
   i2cms_pkg::result_type cur;
   logic pop, push;

   assign head = q_ff[rp_ff];
   always_comb begin
      case (idx_ff)
         2'd0: cur = head.r0;
         2'd1: cur = head.r1;
         default: cur = head.r2;
      endcase
   end
   assign out_valid = fill_ff != 2'd0;
   assign action = cur.action;
   assign data = cur.data;
   assign status = cur.status;
   assign count = cur.count;
   assign last = (idx_ff + 2'd1) == head.num;
   assign pop = out_valid && !out_stall && last;
   assign push = in_valid;
   assign in_ready = fill_ff != 2'd2;

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= in_bundle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; fill_ff <= '0; idx_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
         if (out_valid && !out_stall) idx_ff <= last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   assert property (@(posedge clock) disable iff (reset) fill_ff != 2'd3)
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (head.num != 2'd0 && idx_ff < head.num))
      else $error("result index out of range");
   assert property (@(posedge clock) disable iff (reset)
      (push && fill_ff == 2'd2) |-> 1'b0)
      else $error("push into full queue");
endmodule

>>> sv/i2c_master_transfer_sequencer_unit.sv
`timescale 1ns / 1ps
// a taken request's result bundle is registered into the bundle queue and offered from there
// throughput: one request per cycle while each yields at most one result word;
// a request with k result words holds the output until all k are taken, and once the
// two-entry bundle queue is full the request side stalls
// synchronous active-high reset returns the sequencer to idle, outside any transfer
module i2c_master_transfer_sequencer_unit #(
   parameter int MAX_BYTES    = i2cms_pkg::MaxBytesDefault,
   parameter int MAX_MESSAGES = i2cms_pkg::MaxMessagesDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [6:0] req_slave_address,
   input  logic       req_is_read,
   input  logic       req_skip_start,
   input  logic       req_keep_on_nack,
   input  logic       req_skip_read_ack,
   input  logic       req_skip_stop,
   input  logic [8:0] req_byte_count,
   input  logic       req_final_message,
   input  logic [7:0] req_data_byte,
   input  logic       req_target_nack,
   input  logic       req_arbitration_lost,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_bus_action,
   output logic [7:0] rsp_bus_byte,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_messages_done,
   output logic       rsp_last_of_run
);
   logic ready, bvalid;
   i2cms_pkg::bundle_type bundle;

   assign req_stall = !ready;

   i2cms_front #(.MAX_BYTES(MAX_BYTES), .MAX_MESSAGES(MAX_MESSAGES)) u_front (
      .clock, .reset, .in_valid(req_valid), .in_ready(ready),
      .command(req_command), .slave_address(req_slave_address),
      .is_read(req_is_read), .skip_start(req_skip_start),
      .keep_on_nack(req_keep_on_nack), .skip_read_ack(req_skip_read_ack),
      .skip_stop(req_skip_stop), .byte_count(req_byte_count),
      .final_message(req_final_message), .data_byte(req_data_byte),
      .target_nack(req_target_nack), .arbitration_lost(req_arbitration_lost),
      .out_valid(bvalid), .out_bundle(bundle)
   );

   i2cms_back u_back (
      .clock, .reset, .in_valid(bvalid), .in_bundle(bundle), .in_ready(ready),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .action(rsp_bus_action),
      .data(rsp_bus_byte), .status(rsp_status), .count(rsp_messages_done),
      .last(rsp_last_of_run)
   );
endmodule

>>> test/i2c_master_transfer_sequencer_unit_tb.sv
`timescale 1ns / 1ps
module i2c_master_transfer_sequencer_unit_tb;
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam int WatchdogLimit = 5000;
   localparam int PhaseWords = 103;

   typedef struct packed {
      logic [1:0] command;
      logic [6:0] slave_address;
      logic       is_read;
      logic       skip_start;
      logic       keep_on_nack;
      logic       skip_read_ack;
      logic       skip_stop;
      logic [8:0] byte_count;
      logic       final_message;
      logic [7:0] data_byte;
      logic       target_nack;
      logic       arbitration_lost;
   } word_type;

   localparam int WordBits = $bits(word_type);

   typedef struct packed {
      logic [3:0] action;
      logic [7:0] data;
      logic [1:0] status;
      logic [7:0] count;
      logic       last;
   } bus_step_type;

   typedef struct {
      word_type     w;
      logic         typed;
      int           n;
      bus_step_type r [3];
   } row_type;

   logic clock, reset;
   logic req_valid, req_stall;
   word_type req;
   logic rsp_valid, rsp_stall;
   logic [3:0] rsp_bus_action;
   logic [7:0] rsp_bus_byte;
   logic [1:0] rsp_status;
   logic [7:0] rsp_messages_done;
   logic       rsp_last_of_run;

   i2c_master_transfer_sequencer_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req.command), .req_slave_address(req.slave_address),
      .req_is_read(req.is_read), .req_skip_start(req.skip_start),
      .req_keep_on_nack(req.keep_on_nack), .req_skip_read_ack(req.skip_read_ack),
      .req_skip_stop(req.skip_stop), .req_byte_count(req.byte_count),
      .req_final_message(req.final_message), .req_data_byte(req.data_byte),
      .req_target_nack(req.target_nack),
      .req_arbitration_lost(req.arbitration_lost),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_bus_action(rsp_bus_action), .rsp_bus_byte(rsp_bus_byte),
      .rsp_status(rsp_status), .rsp_messages_done(rsp_messages_done),
      .rsp_last_of_run(rsp_last_of_run)
   );

   // sequencer mirror
   i2cms_pkg::phase_type seq_phase;
   logic       seq_in_transfer;
   int         seq_bytes_left;
   word_type   seq_hdr;
   int         seq_completed;

   bus_step_type expected_steps[$];
   bus_step_type step_buf[$];
   int  errors = 0;
   int  idle_cycles = 0;
   int  send_gap = 0, recv_stall = 0;
   int  sent_words = 0;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   task automatic emit(input logic [3:0] a, input logic [7:0] d,
                       input logic [1:0] s, input logic [7:0] c);
      step_buf.push_back('{a, d, s, c, 1'b0});
   endtask

   task automatic seq_clear();
      seq_phase = i2cms_pkg::PH_IDLE;
      seq_in_transfer = 0;
      seq_bytes_left = 0;
      seq_hdr = '0;
      seq_completed = 0;
   endtask

   task automatic seq_end(input logic [1:0] st);
      if (!seq_hdr.skip_stop) emit(i2cms_pkg::ACT_STOP, 8'd0, i2cms_pkg::ST_OK, 8'd0);
      emit(i2cms_pkg::ACT_DONE, 8'd0, st, seq_completed[7:0]);
      seq_clear();
   endtask

   task automatic seq_finish_msg();
      if (seq_completed < i2cms_pkg::MaxMessagesDefault && seq_completed < 255)
         seq_completed++;
      if (seq_hdr.final_message) seq_end(i2cms_pkg::ST_OK);
      else seq_phase = i2cms_pkg::PH_IDLE;
   endtask

   task automatic seq_read_ack();
      if (seq_hdr.skip_read_ack)
         emit(i2cms_pkg::ACT_NOACK, 8'd0, i2cms_pkg::ST_OK, 8'd0);
      else if (seq_bytes_left > 1)
         emit(i2cms_pkg::ACT_ACK, 8'd0, i2cms_pkg::ST_OK, 8'd0);
      else
         emit(i2cms_pkg::ACT_NACK, 8'd0, i2cms_pkg::ST_OK, 8'd0);
      seq_phase = i2cms_pkg::PH_RREPLY;
   endtask

   task automatic seq_start_data();
      if (seq_bytes_left == 0) seq_finish_msg();
      else if (seq_hdr.is_read) seq_read_ack();
      else seq_phase = i2cms_pkg::PH_WDATA;
   endtask

   // computes the bus steps one word causes and updates the mirror
   task automatic predict_bus_steps(input word_type w);
      step_buf.delete();
      case (w.command)
         i2cms_pkg::CMD_HEADER: begin
            if (seq_phase == i2cms_pkg::PH_IDLE) begin
               seq_hdr = w;
               seq_bytes_left = (w.byte_count > i2cms_pkg::MaxBytesDefault)
                              ? i2cms_pkg::MaxBytesDefault : w.byte_count;
               if (!w.skip_start) begin
                  emit(seq_in_transfer ? i2cms_pkg::ACT_RESTART : i2cms_pkg::ACT_START,
                       8'd0, i2cms_pkg::ST_OK, 8'd0);
                  emit(i2cms_pkg::ACT_SEND, {w.slave_address, w.is_read},
                       i2cms_pkg::ST_OK, 8'd0);
                  seq_in_transfer = 1;
                  seq_phase = i2cms_pkg::PH_ADDR;
               end else begin
                  seq_in_transfer = 1;
                  seq_start_data();
               end
            end
         end
         i2cms_pkg::CMD_WRITE: begin
            if (seq_phase == i2cms_pkg::PH_WDATA) begin
               emit(i2cms_pkg::ACT_SEND, w.data_byte, i2cms_pkg::ST_OK, 8'd0);
               seq_phase = i2cms_pkg::PH_WREPLY;
            end
         end
         i2cms_pkg::CMD_REPLY: begin
            case (seq_phase)
               i2cms_pkg::PH_ADDR: begin
                  if (w.arbitration_lost) seq_end(i2cms_pkg::ST_IO_ERROR);
                  else if (w.target_nack && !seq_hdr.keep_on_nack)
                     seq_end(i2cms_pkg::ST_ADDR_NACK);
                  else seq_start_data();
               end
               i2cms_pkg::PH_WREPLY: begin
                  if (w.arbitration_lost) seq_end(i2cms_pkg::ST_IO_ERROR);
                  else if (w.target_nack && !seq_hdr.keep_on_nack)
                     seq_end(i2cms_pkg::ST_WR_NACK);
                  else begin
                     if (seq_bytes_left > 0) seq_bytes_left--;
                     if (seq_bytes_left == 0) seq_finish_msg();
                     else seq_phase = i2cms_pkg::PH_WDATA;
                  end
               end
               i2cms_pkg::PH_RREPLY: begin
                  emit(i2cms_pkg::ACT_READ, w.data_byte, i2cms_pkg::ST_OK, 8'd0);
                  if (seq_bytes_left > 0) seq_bytes_left--;
                  if (seq_bytes_left == 0) seq_finish_msg();
                  else seq_read_ack();
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      if (step_buf.size() > 0) step_buf[step_buf.size() - 1].last = 1'b1;
   endtask

   task automatic send_word(input word_type w);
      while (send_gap > 0 && $urandom_range(99) < send_gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_words++;
      predict_bus_steps(w);
      foreach (step_buf[i]) expected_steps.push_back(step_buf[i]);
   endtask

   // receiver side and checking
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_steps.size() == 0) begin
               $display("%0t unexpected word: actual %h %h %h %h %b", $time,
                        rsp_bus_action, rsp_bus_byte, rsp_status,
                        rsp_messages_done, rsp_last_of_run);
               errors++;
            end else begin
               bus_step_type e;
               e = expected_steps.pop_front();
               if (e != {rsp_bus_action, rsp_bus_byte, rsp_status,
                         rsp_messages_done, rsp_last_of_run}) begin
                  $display("%0t mismatch: expected %h %h %h %h %b actual %h %h %h %h %b",
                           $time, e.action, e.data, e.status, e.count, e.last,
                           rsp_bus_action, rsp_bus_byte, rsp_status,
                           rsp_messages_done, rsp_last_of_run);
                  errors++;
               end
            end
         end
         rsp_stall <= (recv_stall > 0) && ($urandom_range(99) < recv_stall);
      end
   end

   // watchdog on cycles with no accepted word on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else if (req_valid || expected_steps.size() > 0) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   function automatic word_type mk_hdr(input logic [6:0] a, input logic rd,
         input logic ss, input logic ign, input logic sra, input logic sst,
         input logic [8:0] cnt, input logic fin);
      word_type w;
      w = '0;
      w.command = i2cms_pkg::CMD_HEADER;
      w.slave_address = a; w.is_read = rd; w.skip_start = ss;
      w.keep_on_nack = ign; w.skip_read_ack = sra; w.skip_stop = sst;
      w.byte_count = cnt; w.final_message = fin;
      return w;
   endfunction

   function automatic word_type mk_other(input logic [1:0] c, input logic [7:0] d,
                                         input logic nk, input logic arb);
      word_type w;
      w = '0;
      w.command = c; w.data_byte = d; w.target_nack = nk; w.arbitration_lost = arb;
      return w;
   endfunction

   function automatic word_type rand_word();
      return word_type'(WordBits'({$urandom, $urandom}));
   endfunction

   function automatic word_type noise_fields(input word_type w);
      // randomize fields the command does not look at
      word_type r;
      r = rand_word();
      if (w.command == i2cms_pkg::CMD_HEADER) begin
         r.command = w.command;
         r.slave_address = w.slave_address; r.is_read = w.is_read;
         r.skip_start = w.skip_start; r.keep_on_nack = w.keep_on_nack;
         r.skip_read_ack = w.skip_read_ack; r.skip_stop = w.skip_stop;
         r.byte_count = w.byte_count; r.final_message = w.final_message;
         return r;
      end
      r.command = w.command; r.data_byte = w.data_byte;
      r.target_nack = w.target_nack; r.arbitration_lost = w.arbitration_lost;
      return r;
   endfunction

   function automatic word_type rand_hdr(input logic fin);
      int cnt;
      cnt = ($urandom_range(39) == 0) ? $urandom_range(511) : $urandom_range(4);
      return mk_hdr(7'($urandom_range(127)), 1'($urandom_range(1)),
                    ($urandom_range(5) == 0), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 1'($urandom_range(1)), cnt[8:0], fin);
   endfunction

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_steps.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one well-formed message answered according to the mirror
   task automatic run_message(input word_type h);
      int guard;
      send_word(noise_fields(h));
      guard = 0;
      while (seq_phase != i2cms_pkg::PH_IDLE && guard < 600) begin
         guard++;
         case (seq_phase)
            i2cms_pkg::PH_WDATA:
               send_word(noise_fields(mk_other(i2cms_pkg::CMD_WRITE, 8'($urandom),
                                               1'b0, 1'b0)));
            default:
               send_word(noise_fields(mk_other(i2cms_pkg::CMD_REPLY, 8'($urandom),
                         ($urandom_range(15) == 0), ($urandom_range(40) == 0))));
         endcase
         if ($urandom_range(60) == 0) send_word(rand_word());
      end
   endtask

   row_type rows[$];

   task automatic add_row(input word_type w, input logic typed, input int n,
                          input bus_step_type a, input bus_step_type b,
                          input bus_step_type c);
      row_type r;
      r.w = w; r.typed = typed; r.n = n;
      r.r[0] = a; r.r[1] = b; r.r[2] = c;
      rows.push_back(r);
   endtask

   initial begin
      bus_step_type z;
      int phase_idx;
      int msgs;
      int t;
      z = '0;
      reset = 1'b1;
      req_valid = 1'b0;
      req = '0;
      seq_clear();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows
      add_row(mk_other(i2cms_pkg::CMD_REPLY, 8'hff, 1'b1, 1'b1), 1, 0, z, z, z);
      add_row(mk_other(i2cms_pkg::CMD_WRITE, 8'hff, 1'b0, 1'b0), 1, 0, z, z, z);
      add_row(mk_other(CMD_UNKNOWN, 8'h00, 1'b1, 1'b1), 1, 0, z, z, z);
      add_row(mk_hdr(7'h7f, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 9'd2, 1'b0), 1, 2,
              '{i2cms_pkg::ACT_START, 8'h00, i2cms_pkg::ST_OK, 8'd0, 1'b0},
              '{i2cms_pkg::ACT_SEND, 8'hfe, i2cms_pkg::ST_OK, 8'd0, 1'b1}, z);
      add_row(mk_hdr(7'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 9'd1, 1'b1), 1, 0, z, z, z);
      add_row(mk_other(i2cms_pkg::CMD_REPLY, 8'h00, 1'b0, 1'b0), 0, 0, z, z, z);
      add_row(mk_other(i2cms_pkg::CMD_WRITE, 8'hff, 1'b0, 1'b0), 0, 0, z, z, z);
      add_row(mk_other(i2cms_pkg::CMD_REPLY, 8'h00, 1'b0, 1'b0), 0, 0, z, z, z);
      add_row(mk_other(i2cms_pkg::CMD_WRITE, 8'h00, 1'b0, 1'b0), 0, 0, z, z, z);
      add_row(mk_other(i2cms_pkg::CMD_REPLY, 8'h00, 1'b1, 1'b0), 1, 2,
              '{i2cms_pkg::ACT_STOP, 8'h00, i2cms_pkg::ST_OK, 8'd0, 1'b0},
              '{i2cms_pkg::ACT_DONE, 8'h00, i2cms_pkg::ST_WR_NACK, 8'd0, 1'b1}, z);
      add_row(mk_hdr(7'h00, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 9'd2, 1'b0), 1, 2,
              '{i2cms_pkg::ACT_START, 8'h00, i2cms_pkg::ST_OK, 8'd0, 1'b0},
              '{i2cms_pkg::ACT_SEND, 8'h01, i2cms_pkg::ST_OK, 8'd0, 1'b1}, z);
      add_row(mk_other(i2cms_pkg::CMD_REPLY, 8'h00, 1'b1, 1'b0), 0, 0, z, z, z);
      add_row(mk_other(i2cms_pkg::CMD_REPLY, 8'hff, 1'b1, 1'b1), 0, 0, z, z, z);
      add_row(mk_other(i2cms_pkg::CMD_REPLY, 8'h00, 1'b0, 1'b0), 0, 0, z, z, z);
      add_row(mk_hdr(7'h55, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 9'd0, 1'b0), 0, 0, z, z, z);
      add_row(mk_hdr(7'h2a, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 9'd511, 1'b1), 1, 2,
              '{i2cms_pkg::ACT_RESTART, 8'h00, i2cms_pkg::ST_OK, 8'd0, 1'b0},
              '{i2cms_pkg::ACT_SEND, 8'h55, i2cms_pkg::ST_OK, 8'd0, 1'b1}, z);
      add_row(mk_other(i2cms_pkg::CMD_REPLY, 8'h00, 1'b1, 1'b1), 1, 2,
              '{i2cms_pkg::ACT_STOP, 8'h00, i2cms_pkg::ST_OK, 8'd0, 1'b0},
              '{i2cms_pkg::ACT_DONE, 8'h00, i2cms_pkg::ST_IO_ERROR, 8'd2, 1'b1}, z);
      add_row(mk_hdr(7'h11, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 9'd0, 1'b1), 1, 2,
              '{i2cms_pkg::ACT_START, 8'h00, i2cms_pkg::ST_OK, 8'd0, 1'b0},
              '{i2cms_pkg::ACT_SEND, 8'h22, i2cms_pkg::ST_OK, 8'd0, 1'b1}, z);
      add_row(mk_other(i2cms_pkg::CMD_REPLY, 8'h00, 1'b1, 1'b0), 1, 1,
              '{i2cms_pkg::ACT_DONE, 8'h00, i2cms_pkg::ST_ADDR_NACK, 8'd0, 1'b1}, z, z);
      add_row(mk_hdr(7'h11, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 9'd0, 1'b1), 1, 2,
              '{i2cms_pkg::ACT_STOP, 8'h00, i2cms_pkg::ST_OK, 8'd0, 1'b0},
              '{i2cms_pkg::ACT_DONE, 8'h00, i2cms_pkg::ST_OK, 8'd1, 1'b1}, z);

      foreach (rows[i]) begin
         send_word(rows[i].w);
         if (rows[i].typed) begin
            if (step_buf.size() != rows[i].n) begin
               $display("%0t row %0d: expected %0d words, actual %0d", $time, i,
                        rows[i].n, step_buf.size());
               errors++;
            end else
               for (int k = 0; k < rows[i].n; k++)
                  if (step_buf[k] != rows[i].r[k]) begin
                     $display("%0t row %0d word %0d: expected %h actual %h", $time,
                              i, k, rows[i].r[k], step_buf[k]);
                     errors++;
                  end
         end
      end
      drain();

      // random transfers across idling phases
      for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
         case (phase_idx)
            0: begin send_gap = 0;  recv_stall = 0;  end
            1: begin send_gap = 59; recv_stall = 0;  end
            2: begin send_gap = 0;  recv_stall = 59; end
            default: begin send_gap = 16; recv_stall = 16; end
         endcase
         t = 0;
         while (sent_words < rows.size() + PhaseWords * (phase_idx + 1)) begin
            msgs = $urandom_range(3) + 1;
            for (int m = 0; m < msgs; m++)
               run_message(rand_hdr(m == msgs - 1));
            if (t == 5) drain();
            t++;
         end
         drain();
      end

      send_gap = 0;
      recv_stall = 0;
      drain();
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
